@@ rtl/fragment_header_deframer_defines.svh @@
// Assertion macros shared by the deframer modules.
`ifndef FRAGMENT_HEADER_DEFRAMER_DEFINES_SVH
`define FRAGMENT_HEADER_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FHD_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FHD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fhd_pkg.sv @@
// Types and constants of the fragment header deframer.
`timescale 1ns / 1ps
`default_nettype none
package fhd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FRAGS_W = 12;
  localparam int unsigned SIZE_W  = 11;

  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h3a;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TOTAL   = 3'd1,
    PH_NUMBER  = 3'd2,
    PH_SIZE    = 3'd3,
    PH_NAME    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [FRAGS_W-1:0]  total_frags;
    logic [FRAGS_W-1:0]  frag_number;
    logic [SIZE_W-1:0]   payload_size;
    logic [BYTE_W-1:0]   out_byte;
    logic                last;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/fhd_if.sv @@
// Valid/ready channel interfaces for input bytes, results and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface fhd_in_if;
  import fhd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              start_req;
  modport source (output valid, in_byte, start_req, input ready);
  modport sink (input valid, in_byte, start_req, output ready);
endinterface

interface fhd_out_if;
  import fhd_pkg::*;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [FRAGS_W-1:0] total_frags;
  logic [FRAGS_W-1:0] frag_number;
  logic [SIZE_W-1:0]  payload_size;
  logic [BYTE_W-1:0]  out_byte;
  logic               last;
  modport source (output valid, kind, total_frags, frag_number, payload_size, out_byte,
                  last, input ready);
  modport sink (input valid, kind, total_frags, frag_number, payload_size, out_byte,
                last, output ready);
endinterface

interface fhd_cfg_if;
  import fhd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/fhd_parser.sv @@
// Per-byte header parser: field accumulators, phase tracking and result forming.
`timescale 1ns / 1ps
`default_nettype none
`include "fragment_header_deframer_defines.svh"
module fhd_parser #(
  parameter int unsigned FRAG_LIMIT    = 4096,
  parameter int unsigned PAYLOAD_LIMIT = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire logic [fhd_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       start_req,
  input  wire logic [fhd_pkg::BYTE_W-1:0] delimiter,
  output      logic                       res_valid,
  output      fhd_pkg::res_t              res
);
  import fhd_pkg::*;

  localparam int unsigned FW = $clog2(FRAG_LIMIT);
  localparam int unsigned PW = $clog2(PAYLOAD_LIMIT + 1);
  localparam logic [FW+3:0] TOT_MAX  = (FW+4)'(FRAG_LIMIT - 1);
  localparam logic [PW+3:0] SIZE_MAX = (PW+4)'(PAYLOAD_LIMIT);

  phase_t        phase, phase_next, ph_eff;
  logic [FW-1:0] total_acc, total_next, total_eff;
  logic [FW-1:0] number_acc, number_next, number_eff;
  logic [PW-1:0] size_acc, size_next, size_eff;
  logic [PW-1:0] bytes_left, bytes_left_next, bl_eff, bl_dec;
  logic          digits_stopped, digits_stopped_next, stopped_eff;
  logic          is_delim, is_digit;
  logic [3:0]    digit;
  logic [FW+3:0] tot_mac, num_mac;
  logic [PW+3:0] size_mac;
  logic [31:0]   tot_wide, num_wide, size_wide;

  // A start mark restarts the parse with this byte as the first one.
  always_comb begin
    ph_eff      = start_req ? PH_TOTAL : phase;
    total_eff   = start_req ? '0 : total_acc;
    number_eff  = start_req ? '0 : number_acc;
    size_eff    = start_req ? '0 : size_acc;
    bl_eff      = start_req ? '0 : bytes_left;
    stopped_eff = start_req ? 1'b0 : digits_stopped;
    is_delim    = (in_byte == delimiter);
    is_digit    = (in_byte >= DIGIT_ZERO) && (in_byte <= DIGIT_NINE);
    digit       = in_byte[3:0];
    bl_dec      = (bl_eff != '0) ? bl_eff - PW'(1) : bl_eff;
    tot_mac     = ((FW+4)'(total_eff) << 3) + ((FW+4)'(total_eff) << 1) + (FW+4)'(digit);
    num_mac     = ((FW+4)'(number_eff) << 3) + ((FW+4)'(number_eff) << 1) + (FW+4)'(digit);
    size_mac    = ((PW+4)'(size_eff) << 3) + ((PW+4)'(size_eff) << 1) + (PW+4)'(digit);
    tot_wide    = 32'(total_eff);
    num_wide    = 32'(number_eff);
    size_wide   = 32'(size_eff);
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (take) begin
      phase_next = ph_eff;
      unique case (ph_eff)
        PH_TOTAL:   if (is_delim) phase_next = PH_NUMBER;
        PH_NUMBER:  if (is_delim) phase_next = PH_SIZE;
        PH_SIZE:    if (is_delim) phase_next = PH_NAME;
        PH_NAME:    if (is_delim) phase_next = (size_eff == '0) ? PH_DONE : PH_PAYLOAD;
        PH_PAYLOAD: if (bl_dec == '0) phase_next = PH_DONE;
        PH_IDLE, PH_DONE: phase_next = ph_eff;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // Accumulators and the result word.
  always_comb begin
    total_next          = total_acc;
    number_next         = number_acc;
    size_next           = size_acc;
    bytes_left_next     = bytes_left;
    digits_stopped_next = digits_stopped;
    res_valid           = 1'b0;
    res                 = '0;
    if (take) begin
      total_next          = total_eff;
      number_next         = number_eff;
      size_next           = size_eff;
      bytes_left_next     = bl_eff;
      digits_stopped_next = stopped_eff;
      unique case (ph_eff)
        PH_TOTAL, PH_NUMBER, PH_SIZE: begin
          if (is_delim) begin
            digits_stopped_next = 1'b0;
          end else if (!stopped_eff && is_digit) begin
            if (ph_eff == PH_TOTAL) begin
              total_next = (tot_mac > TOT_MAX) ? FW'(TOT_MAX) : FW'(tot_mac);
            end else if (ph_eff == PH_NUMBER) begin
              number_next = (num_mac > TOT_MAX) ? FW'(TOT_MAX) : FW'(num_mac);
            end else begin
              size_next = (size_mac > SIZE_MAX) ? PW'(SIZE_MAX) : PW'(size_mac);
            end
          end else begin
            digits_stopped_next = 1'b1;
          end
        end
        PH_NAME: begin
          res_valid = 1'b1;
          if (is_delim) begin
            bytes_left_next  = size_eff;
            res.kind         = KIND_HEADER;
            res.total_frags  = tot_wide[FRAGS_W-1:0];
            res.frag_number  = num_wide[FRAGS_W-1:0];
            res.payload_size = size_wide[SIZE_W-1:0];
            res.last         = (size_eff == '0);
          end else begin
            res.kind     = KIND_NAME;
            res.out_byte = in_byte;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = bl_dec;
          res_valid       = 1'b1;
          res.kind        = KIND_PAYLOAD;
          res.out_byte    = in_byte;
          res.last        = (bl_dec == '0);
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      total_acc      <= '0;
      number_acc     <= '0;
      size_acc       <= '0;
      bytes_left     <= '0;
      digits_stopped <= 1'b0;
    end else begin
      phase          <= phase_next;
      total_acc      <= total_next;
      number_acc     <= number_next;
      size_acc       <= size_next;
      bytes_left     <= bytes_left_next;
      digits_stopped <= digits_stopped_next;
    end
  end

  `FHD_ASSERT_NEXT(a_last_ends_datagram, clk, rst, res_valid && res.last, phase == PH_DONE, "last result did not end the datagram")
  `FHD_ASSERT_IMPL(a_payload_count_sane, clk, rst, phase == PH_PAYLOAD, bytes_left != '0 && bytes_left <= size_acc, "payload count out of range")
  `FHD_ASSERT_IMPL(a_quiet_outside_body, clk, rst, take && !start_req && (phase == PH_IDLE || phase == PH_TOTAL || phase == PH_NUMBER || phase == PH_SIZE || phase == PH_DONE), !res_valid, "result outside name or payload")

endmodule
`default_nettype wire

@@ rtl/fhd_obuf.sv @@
// Two-entry output buffer that decouples the parser from result back-pressure.
`timescale 1ns / 1ps
`default_nettype none
`include "fragment_header_deframer_defines.svh"
module fhd_obuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fhd_pkg::res_t push_word,
  output      logic          push_ready,
  fhd_out_if.source          dout
);
  import fhd_pkg::*;

  res_t       head, tail;
  logic [1:0] count;
  logic       pop;

  assign pop        = dout.valid && dout.ready;
  assign push_ready = (count != 2'd2);

  assign dout.valid        = (count != 2'd0);
  assign dout.kind         = head.kind;
  assign dout.total_frags  = head.total_frags;
  assign dout.frag_number  = head.frag_number;
  assign dout.payload_size = head.payload_size;
  assign dout.out_byte     = head.out_byte;
  assign dout.last         = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Word storage: head is presented, tail holds the overflow word.
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) head <= push_word;
        else tail <= push_word;
      end
      2'b01: head <= tail;
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_word;
        end else begin
          head <= tail;
          tail <= push_word;
        end
      end
      default: head <= head;
    endcase
  end

  `FHD_ASSERT_IMPL(a_no_overflow, clk, rst, push, count != 2'd2, "push into full buffer")
  `FHD_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count != 2'd3, "buffer count out of range")
  `FHD_ASSERT_NEXT(a_full_holds, clk, rst, count == 2'd2 && !pop, count == 2'd2 && $stable(head), "full buffer lost its head word")

endmodule
`default_nettype wire

@@ rtl/fragment_header_deframer.sv @@
// Each result is registered into the output buffer and shown on dout as its head word.
// Throughput: one byte per cycle; din stalls only while both output buffer words are held.
// The two-word output buffer lets a new byte in while a finished word waits.
// Reset: phase back to waiting for a start mark, accumulators cleared,
// delimiter set to ':', output buffer emptied.
`timescale 1ns / 1ps
`default_nettype none
module fragment_header_deframer #(
  parameter int unsigned FRAG_LIMIT    = 4096,
  parameter int unsigned PAYLOAD_LIMIT = 1024
) (
  input wire logic  clk,
  input wire logic  rst,
  fhd_in_if.sink    din,
  fhd_out_if.source dout,
  fhd_cfg_if.sink   cfg
);
  import fhd_pkg::*;

  logic [BYTE_W-1:0] delimiter;
  logic              take;
  logic              res_valid;
  logic              buf_ready;
  res_t              res;

  assign cfg.ready = 1'b1;
  assign din.ready = buf_ready;
  assign take      = din.valid && buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (cfg.valid) begin
      delimiter <= cfg.data;
    end
  end

  fhd_parser #(
    .FRAG_LIMIT    (FRAG_LIMIT),
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (din.in_byte),
    .start_req (din.start_req),
    .delimiter (delimiter),
    .res_valid (res_valid),
    .res       (res)
  );

  fhd_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_word  (res),
    .push_ready (buf_ready),
    .dout       (dout)
  );

endmodule
`default_nettype wire

@@ test/fragment_header_deframer_tb.sv @@
// Self-checking testbench for the fragment header deframer: directed table, then random datagrams.
`timescale 1ns / 1ps
module fragment_header_deframer_tb;
  import fhd_pkg::*;

  localparam int unsigned FRAG_LIMIT    = 4096;
  localparam int unsigned PAYLOAD_LIMIT = 1024;
  localparam int FRAG_MAX    = FRAG_LIMIT - 1;
  localparam int SIZE_MAX    = PAYLOAD_LIMIT;
  localparam int PHASE_BYTES = 340;
  localparam int CYCLE_LIMIT = 200000;

  localparam res_t NO_RES = '{KIND_HEADER, 12'd0, 12'd0, 11'd0, 8'd0, 1'b0};

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              s;
    logic              typed;
    res_t              want;
  } dir_row_t;

  // Directed rows; a typed result replaces the predicted one for that word.
  localparam dir_row_t DIR_TAB [0:24] = '{
    '{"x", 1'b0, 1'b0, NO_RES},   // no start seen yet: dropped
    '{"9", 1'b1, 1'b0, NO_RES},
    '{"9", 1'b0, 1'b0, NO_RES},
    '{"9", 1'b0, 1'b0, NO_RES},
    '{"9", 1'b0, 1'b0, NO_RES},   // total saturates
    '{":", 1'b0, 1'b0, NO_RES},
    '{":", 1'b0, 1'b0, NO_RES},   // empty fragment number
    '{"2", 1'b0, 1'b0, NO_RES},
    '{"+", 1'b0, 1'b0, NO_RES},   // sign stops the digits
    '{"5", 1'b0, 1'b0, NO_RES},
    '{":", 1'b0, 1'b0, NO_RES},
    '{"N", 1'b0, 1'b1, '{KIND_NAME, 12'd0, 12'd0, 11'd0, "N", 1'b0}},
    '{":", 1'b0, 1'b1, '{KIND_HEADER, 12'd4095, 12'd0, 11'd2, 8'h00, 1'b0}},
    '{8'hff, 1'b0, 1'b1, '{KIND_PAYLOAD, 12'd0, 12'd0, 11'd0, 8'hff, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{KIND_PAYLOAD, 12'd0, 12'd0, 11'd0, 8'h00, 1'b1}},
    '{"z", 1'b0, 1'b0, NO_RES},   // after last: dropped
    '{":", 1'b1, 1'b0, NO_RES},
    '{" ", 1'b0, 1'b0, NO_RES},   // space stops the digits
    '{"7", 1'b0, 1'b0, NO_RES},
    '{":", 1'b0, 1'b0, NO_RES},
    '{"0", 1'b0, 1'b0, NO_RES},
    '{":", 1'b0, 1'b0, NO_RES},
    '{":", 1'b0, 1'b1, '{KIND_HEADER, 12'd0, 12'd0, 11'd0, 8'h00, 1'b1}},
    '{"8", 1'b1, 1'b0, NO_RES},
    '{"1", 1'b1, 1'b0, NO_RES}    // start again mid-datagram
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fhd_in_if  in_ch ();
  fhd_out_if res_ch ();
  fhd_cfg_if cfg_ch ();

  fragment_header_deframer #(
    .FRAG_LIMIT   (FRAG_LIMIT),
    .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
  ) dut (
    .clk (clk),
    .rst (rst),
    .din (in_ch),
    .dout(res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [BYTE_W-1:0] delim = DELIM_RESET;
  phase_t ph = PH_IDLE;
  int     total_acc;
  int     number_acc;
  int     size_acc;
  logic   stopped;
  int     bytes_left;
  int     parsed_bytes;

  res_t frag_q [$];
  int   err_cnt;
  int   send_idle;
  int   recv_idle;
  logic new_dg;
  int unsigned cycles;

  function automatic int add_digit(input int acc, input int d, input int max);
    int v;
    v = acc * 10 + d;
    return (v > max) ? max : v;
  endfunction

  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic s,
                              output logic has_res, output res_t r);
    int d;
    has_res = 1'b0;
    r = NO_RES;
    if (s) begin
      ph = PH_TOTAL;
      total_acc = 0;
      number_acc = 0;
      size_acc = 0;
      stopped = 1'b0;
      bytes_left = 0;
    end
    if (ph != PH_IDLE && ph != PH_DONE) parsed_bytes++;
    case (ph)
      PH_TOTAL, PH_NUMBER, PH_SIZE: begin
        if (b == delim) begin
          ph = phase_t'(ph + 1);
          stopped = 1'b0;
        end else if (!stopped && b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
          d = b - DIGIT_ZERO;
          if (ph == PH_TOTAL) total_acc = add_digit(total_acc, d, FRAG_MAX);
          else if (ph == PH_NUMBER) number_acc = add_digit(number_acc, d, FRAG_MAX);
          else size_acc = add_digit(size_acc, d, SIZE_MAX);
        end else begin
          stopped = 1'b1;
        end
      end
      PH_NAME: begin
        has_res = 1'b1;
        if (b == delim) begin
          bytes_left = size_acc;
          r.kind = KIND_HEADER;
          r.total_frags = total_acc[FRAGS_W-1:0];
          r.frag_number = number_acc[FRAGS_W-1:0];
          r.payload_size = size_acc[SIZE_W-1:0];
          r.last = (bytes_left == 0);
          ph = (bytes_left == 0) ? PH_DONE : PH_PAYLOAD;
        end else begin
          r.kind = KIND_NAME;
          r.out_byte = b;
        end
      end
      PH_PAYLOAD: begin
        has_res = 1'b1;
        if (bytes_left > 0) bytes_left--;
        r.kind = KIND_PAYLOAD;
        r.out_byte = b;
        if (bytes_left == 0) begin
          r.last = 1'b1;
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  function automatic string fmt_res(input res_t r);
    return $sformatf("kind=%0d total=%0d number=%0d size=%0d byte=%02h last=%0b",
                     r.kind, r.total_frags, r.frag_number, r.payload_size, r.out_byte,
                     r.last);
  endfunction

  function automatic void flag_err(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic s, input logic typed,
                           input res_t typed_res);
    logic has_res;
    res_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.start_req <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    deframe_byte(b, s, has_res, r);
    if (typed) frag_q.push_back(typed_res);
    else if (has_res) frag_q.push_back(r);
  endtask

  task automatic send_b(input logic [BYTE_W-1:0] b);
    send_item(b, new_dg, 1'b0, NO_RES);
    new_dg = 1'b0;
  endtask

  task automatic send_txt(input string t);
    for (int i = 0; i < t.len(); i++) send_b(t[i]);
  endtask

  function automatic logic [BYTE_W-1:0] pick_junk();
    logic [BYTE_W-1:0] v;
    do v = $urandom_range(0, 255);
    while ((v >= DIGIT_ZERO && v <= DIGIT_NINE) || v == delim);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_name();
    logic [BYTE_W-1:0] v;
    do v = $urandom_range(0, 255); while (v == delim);
    return v;
  endfunction

  task automatic send_number(input int maxv);
    case ($urandom_range(0, 9))
      0: ;
      1: send_txt($sformatf("%0d", $urandom_range(0, 99999)));
      2: begin
        case ($urandom_range(0, 2))
          0: send_b("+");
          1: send_b("-");
          default: send_b(" ");
        endcase
        send_txt($sformatf("%0d", $urandom_range(0, maxv)));
      end
      3: begin
        send_txt($sformatf("%0d", $urandom_range(0, maxv)));
        send_b(pick_junk());
        send_txt($sformatf("%0d", $urandom_range(0, 99)));
      end
      4: send_txt($sformatf("00%0d", $urandom_range(0, maxv)));
      default: send_txt($sformatf("%0d", $urandom_range(0, maxv)));
    endcase
    send_b(delim);
  endtask

  task automatic send_datagram(input logic full_size);
    int n;
    // stray words between datagrams
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_item($urandom_range(0, 255), 1'b0, 1'b0, NO_RES);
    new_dg = 1'b1;
    if (full_size) begin
      send_txt("3");
      send_b(delim);
      send_txt("2");
      send_b(delim);
      send_txt("1024");
      send_b(delim);
    end else begin
      send_number(20);
      if ($urandom_range(0, 19) == 0) return;
      send_number(20);
      send_number(6);
    end
    repeat ($urandom_range(0, 4)) send_b(pick_name());
    if (!full_size && $urandom_range(0, 14) == 0) return;
    send_b(delim);
    n = bytes_left;
    if (full_size) begin
      // top-of-range size: send the head of the payload only
      n = $urandom_range(24, 40);
    end else begin
      // cut long payloads short; the next start mark recovers
      if (n > 40) n = $urandom_range(0, 20);
      if ($urandom_range(0, 11) == 0) n = $urandom_range(0, n);
    end
    repeat (n) send_b($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_b($urandom_range(0, 255));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (frag_q.size() != 0) @(posedge clk);
    // a word with no result may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delim(input logic [BYTE_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    delim = v;
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input logic [BYTE_W-1:0] dlm,
                           input logic full_size, input logic hold);
    int goal;
    drain();
    write_delim(dlm);
    send_idle = s_idle;
    recv_idle = r_idle;
    if (full_size) send_datagram(1'b1);
    goal = parsed_bytes + PHASE_BYTES;
    while (parsed_bytes < goal) begin
      send_datagram(1'b0);
      // hold the sender until every result is out
      if (hold && parsed_bytes >= goal - PHASE_BYTES / 2) begin
        drain();
        hold = 1'b0;
      end
    end
  endtask

  // Receiver and result checker
  initial begin
    res_t got_r;
    res_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got_r = '{res_ch.kind, res_ch.total_frags, res_ch.frag_number, res_ch.payload_size,
                  res_ch.out_byte, res_ch.last};
        if (frag_q.size() == 0) begin
          flag_err($sformatf("unexpected result: %s", fmt_res(got_r)));
        end else begin
          want = frag_q.pop_front();
          if (want.kind !== got_r.kind || want.total_frags !== got_r.total_frags ||
              want.frag_number !== got_r.frag_number ||
              want.payload_size !== got_r.payload_size ||
              want.out_byte !== got_r.out_byte || want.last !== got_r.last)
            flag_err($sformatf("mismatch: expected %s, got %s", fmt_res(want),
                               fmt_res(got_r)));
        end
      end
      res_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.start_req <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIR_TAB[i])
      send_item(DIR_TAB[i].b, DIR_TAB[i].s, DIR_TAB[i].typed, DIR_TAB[i].want);
    run_phase(31, 54, 8'h00, 1'b0, 1'b1);
    run_phase(54, 31, 8'hff, 1'b0, 1'b0);
    run_phase(0, 0, "/", 1'b1, 1'b0);
    drain();
    if (err_cnt == 0 && frag_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ fragment_header_deframer.f @@
+incdir+rtl
rtl/fhd_pkg.sv
rtl/fhd_if.sv
rtl/fhd_parser.sv
rtl/fhd_obuf.sv
rtl/fragment_header_deframer.sv
test/fragment_header_deframer_tb.sv
